### hw/rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg : shared types and constants for the scancode buffer
// Set-1 modifier codes, flag bit positions, keymap column codes and the
// modifier decode used by the top level.
// ----------------------------------------------------------------------------
package smf_pkg;

    // Beat kind carried on s_tuser
    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // Keymap column reported on a pop
    typedef enum logic [2:0] {
        COL_NORMAL   = 3'd0,
        COL_SHIFT    = 3'd1,
        COL_CTRL     = 3'd2,
        COL_ALT      = 3'd3,
        COL_CTRL_ALT = 3'd4
    } col_t;

    // Set-1 modifier and lock scancodes
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_BRK   = 8'hB6;
    localparam logic [7:0] SC_LSHIFT_BRK   = 8'hAA;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK     = 8'h9D;
    localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
    localparam logic [7:0] SC_ALT_BRK      = 8'hB8;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_NUM_MAKE     = 8'h45;
    localparam logic [7:0] SC_CAPS_TOGGLE  = 8'hBA;
    localparam logic [7:0] SC_NUM_TOGGLE   = 8'hC5;
    localparam logic [7:0] SC_SCRL_TOGGLE  = 8'hE0;

    // Modifier flag bit positions
    localparam int FLAG_SCROLL = 0;
    localparam int FLAG_NUM    = 1;
    localparam int FLAG_CAPS   = 2;
    localparam int FLAG_SHIFT  = 3;
    localparam int FLAG_CTRL   = 4;
    localparam int FLAG_ALT    = 5;

    localparam int FLAGS_W = 6;
    localparam int LOCK_W  = 3;
    localparam int HELD_W  = 6;
    localparam int CODE_W  = 8;

    typedef logic [FLAGS_W-1:0] flags_t;

    typedef struct packed {
        logic   is_mod;
        flags_t flags;
    } mod_dec_t;

    // Applies one scancode to the flag set; is_mod marks codes kept out of the buffer.
    function automatic mod_dec_t mod_decode(input logic [7:0] sc, input flags_t flags);
        mod_dec_t d;
        d.is_mod = 1'b1;
        d.flags  = flags;
        unique case (sc)
            SC_RSHIFT_MAKE, SC_LSHIFT_MAKE: d.flags[FLAG_SHIFT] = 1'b1;
            SC_RSHIFT_BRK,  SC_LSHIFT_BRK:  d.flags[FLAG_SHIFT] = 1'b0;
            SC_CTRL_MAKE:                   d.flags[FLAG_CTRL]  = 1'b1;
            SC_CTRL_BRK:                    d.flags[FLAG_CTRL]  = 1'b0;
            SC_ALT_MAKE:                    d.flags[FLAG_ALT]   = 1'b1;
            SC_ALT_BRK:                     d.flags[FLAG_ALT]   = 1'b0;
            SC_CAPS_MAKE, SC_NUM_MAKE:      d.flags = flags;
            SC_CAPS_TOGGLE:                 d.flags[FLAG_CAPS]   = ~flags[FLAG_CAPS];
            SC_NUM_TOGGLE:                  d.flags[FLAG_NUM]    = ~flags[FLAG_NUM];
            SC_SCRL_TOGGLE:                 d.flags[FLAG_SCROLL] = ~flags[FLAG_SCROLL];
            default:                        d.is_mod = 1'b0;
        endcase
        return d;
    endfunction

    // Column priority: shift, ctrl+alt, ctrl, alt, normal
    function automatic col_t pick_column(input flags_t flags);
        col_t c;
        priority if (flags[FLAG_SHIFT]) c = COL_SHIFT;
        else if (flags[FLAG_CTRL])      c = flags[FLAG_ALT] ? COL_CTRL_ALT : COL_CTRL;
        else if (flags[FLAG_ALT])       c = COL_ALT;
        else                            c = COL_NORMAL;
        return c;
    endfunction

endpackage

### hw/rtl/smf_ram.sv
// ----------------------------------------------------------------------------
// smf_ram : generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/scancode_modifier_fifo_top.sv
// ----------------------------------------------------------------------------
// scancode_modifier_fifo_top : keyboard scancode buffer with modifier tracking
// Queues set-1 scancodes in a ring buffer, tracks shift/ctrl/alt and lock
// flags, and pops codes with the keymap column that applies at pop time.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: s_tuser[0] selects the beat kind (0 = scancode from the
//    keyboard in s_tdata[7:0], 1 = pop one buffered code). Every accepted
//    beat yields exactly one result beat on the m_ side.
//  - Modifier and lock codes only change flags and are never queued. Other
//    codes go into a DEPTH-entry buffer; when it is full the code is dropped
//    and dropped_full is set (beep request).
//  - Path: the RAM has a registered read port, so every accepted beat
//    passes one pending stage (waiting on RAM data) and then the output
//    register, which drives m_tvalid.
//  - Throughput: one beat per cycle if not stalled; each beat does one RAM
//    write or read, and a pop never reads a slot written in the same cycle.
//  - Stall: when m_tready is low the output register holds, the pending
//    stage fills, and s_tready drops until the output register drains.
//  - Reset (aresetn low, synchronous): pointers, fill count, modifier and
//    lock flags and both pipeline stages clear. The RAM contents are not
//    cleared and need no sweep; only written slots are ever popped.
// ----------------------------------------------------------------------------
module scancode_modifier_fifo_top #(
    parameter int DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    input  logic [0:0]  s_tuser,   // [0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] code, [10:8] map_column,
                                   // [11] dropped_full, [12] was_modifier,
                                   // [15:13] lock_flags, [21:16] held_count,
                                   // [23:22] zero
    output logic [0:0]  m_tuser    // [0] code_valid
);
    import smf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Buffer control state
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg,   fill_next;
    flags_t            flags_reg,  flags_next;

    // Pending stage: everything but the popped byte, which arrives from RAM
    logic              p_valid_reg;
    logic              p_code_valid_reg;
    col_t              p_col_reg;
    logic              p_drop_reg;
    logic              p_mod_reg;
    logic [LOCK_W-1:0] p_lock_reg;
    logic [HELD_W-1:0] p_held_reg;

    // Output register
    logic              o_valid_reg;
    logic              o_code_valid_reg;
    logic [CODE_W-1:0] o_code_reg;
    col_t              o_col_reg;
    logic              o_drop_reg;
    logic              o_mod_reg;
    logic [LOCK_W-1:0] o_lock_reg;
    logic [HELD_W-1:0] o_held_reg;

    logic              accept;
    logic              p_move;
    op_t               op;
    mod_dec_t          dec;
    logic              full;
    logic              empty;
    logic              push;
    logic              drop;
    logic              pop;
    logic [CODE_W-1:0] ram_rd_data;
    logic [CNT_W+HELD_W-1:0] held_ext;

    assign op     = op_t'(s_tuser[0]);
    assign dec    = mod_decode(s_tdata, flags_reg);
    assign full   = (fill_reg == CNT_W'(DEPTH));
    assign empty  = (fill_reg == '0);

    // Pending beat moves on when the output register is free or draining
    assign p_move   = p_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || p_move;
    assign accept   = s_tvalid && s_tready;

    assign push = accept && (op == OP_KEY) && !dec.is_mod && !full;
    assign drop = accept && (op == OP_KEY) && !dec.is_mod && full;
    assign pop  = accept && (op == OP_READ) && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        flags_next  = flags_reg;
        if (accept && (op == OP_KEY)) begin
            flags_next = dec.flags;
        end
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    // held_count is the fill level masked to its 6-bit field
    assign held_ext = {{HELD_W{1'b0}}, fill_next};

    smf_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_code_store (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (s_tdata),
        .rd_en   (pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            flags_reg   <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            flags_reg  <= flags_next;
            if (accept) begin
                p_valid_reg <= 1'b1;
            end else if (p_move) begin
                p_valid_reg <= 1'b0;
            end
            if (p_move) begin
                o_valid_reg <= 1'b1;
            end else if (m_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_code_valid_reg <= pop;
            p_col_reg        <= pop ? pick_column(flags_reg) : COL_NORMAL;
            p_drop_reg       <= drop;
            p_mod_reg        <= (op == OP_KEY) && dec.is_mod;
            p_lock_reg       <= flags_next[LOCK_W-1:0];
            p_held_reg       <= held_ext[HELD_W-1:0];
        end
        if (p_move) begin
            o_code_valid_reg <= p_code_valid_reg;
            o_code_reg       <= p_code_valid_reg ? ram_rd_data : '0;
            o_col_reg        <= p_col_reg;
            o_drop_reg       <= p_drop_reg;
            o_mod_reg        <= p_mod_reg;
            o_lock_reg       <= p_lock_reg;
            o_held_reg       <= p_held_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_code_valid_reg;
    assign m_tdata  = {2'b00, o_held_reg, o_lock_reg, o_mod_reg, o_drop_reg,
                       o_col_reg, o_code_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill level above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty buffer with unequal pointers");

    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("full buffer with unequal pointers");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (fill_reg == $past(fill_reg) - 1'b1))
        else $error("pop did not lower the fill level");

    a_pend_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> !(p_code_valid_reg && (p_drop_reg || p_mod_reg)))
        else $error("pending beat is both a pop and a key beat");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb : scancode buffer stream testbench
// Streams key and pop beats into the scancode buffer, mirrors its buffer and
// modifier/lock flags beat by beat, and checks each result beat field by
// field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smf_pkg::*;

    localparam int DEPTH          = 32;
    localparam int RANDOM_ITEMS   = 1700;
    // Longest quiet stretch of a correct run: a sender gap plus a receiver
    // stall plus the pipeline latency. Taken well over that.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 12;

    typedef struct packed {
        op_t        op;
        logic [7:0] sc;
        logic       hold_until_empty;   // sender waits for all results first
    } key_beat_t;

    typedef struct packed {
        logic [7:0] code;
        logic       code_valid;
        col_t       column;
        logic       dropped;
        logic       was_modifier;
        logic [2:0] locks;
        logic [5:0] held;
    } key_report_t;

    // ---------------------------------------------------------------- DUT I/O
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;      // [7:0] scancode
    logic [0:0]  s_tuser  = 1'b0;       // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;               // [7:0] code, [10:8] map_column,
                                        // [11] dropped_full, [12] was_modifier,
                                        // [15:13] lock_flags, [21:16] held_count
    logic [0:0]  m_tuser;               // [0] code_valid

    scancode_modifier_fifo_top #(
        .DEPTH (DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------- shared state
    key_beat_t   key_stream[$];         // beats waiting to be sent
    key_report_t expected_reports[$];   // one per accepted beat, in order
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          send_gap    = 0;
    int          stall_left  = 0;
    logic        no_idle     = 1'b0;    // stretches with back-to-back beats

    // Mirror of the buffer and flag register
    logic [7:0]       key_mirror[DEPTH];
    int               mirror_wr   = 0;
    int               mirror_rd   = 0;
    int               mirror_fill = 0;
    logic [FLAGS_W-1:0] mod_flags = '0;

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random byte, or one of the modifier/lock codes mod_pct percent of the time
    function automatic logic [7:0] pick_scancode(int mod_pct);
        if ($urandom_range(0, 99) >= mod_pct) return 8'($urandom);
        case ($urandom_range(0, 12))
            0:       return SC_RSHIFT_MAKE;
            1:       return SC_LSHIFT_MAKE;
            2:       return SC_RSHIFT_BRK;
            3:       return SC_LSHIFT_BRK;
            4:       return SC_CTRL_MAKE;
            5:       return SC_CTRL_BRK;
            6:       return SC_ALT_MAKE;
            7:       return SC_ALT_BRK;
            8:       return SC_CAPS_MAKE;
            9:       return SC_NUM_MAKE;
            10:      return SC_CAPS_TOGGLE;
            11:      return SC_NUM_TOGGLE;
            default: return SC_SCRL_TOGGLE;
        endcase
    endfunction

    task automatic add_beat(input op_t op, input logic [7:0] sc);
        key_stream.push_back('{op: op, sc: sc, hold_until_empty: 1'b0});
    endtask

    // Applies one accepted beat to the mirror and queues the result it must give
    task automatic track_keyboard_step(input op_t op, input logic [7:0] sc);
        key_report_t r;
        logic        is_mod;
        r      = '0;
        is_mod = 1'b1;
        if (op == OP_KEY) begin
            case (sc)
                SC_RSHIFT_MAKE, SC_LSHIFT_MAKE: mod_flags[FLAG_SHIFT] = 1'b1;
                SC_RSHIFT_BRK, SC_LSHIFT_BRK:   mod_flags[FLAG_SHIFT] = 1'b0;
                SC_CTRL_MAKE:                   mod_flags[FLAG_CTRL]  = 1'b1;
                SC_CTRL_BRK:                    mod_flags[FLAG_CTRL]  = 1'b0;
                SC_ALT_MAKE:                    mod_flags[FLAG_ALT]   = 1'b1;
                SC_ALT_BRK:                     mod_flags[FLAG_ALT]   = 1'b0;
                SC_CAPS_MAKE, SC_NUM_MAKE:      ;   // swallowed, no flag change
                SC_CAPS_TOGGLE: mod_flags[FLAG_CAPS]   = ~mod_flags[FLAG_CAPS];
                SC_NUM_TOGGLE:  mod_flags[FLAG_NUM]    = ~mod_flags[FLAG_NUM];
                SC_SCRL_TOGGLE: mod_flags[FLAG_SCROLL] = ~mod_flags[FLAG_SCROLL];
                default:        is_mod = 1'b0;
            endcase
            if (is_mod) begin
                r.was_modifier = 1'b1;
            end else if (mirror_fill < DEPTH) begin
                key_mirror[mirror_wr] = sc;
                mirror_wr   = (mirror_wr == DEPTH - 1) ? 0 : mirror_wr + 1;
                mirror_fill = mirror_fill + 1;
            end else begin
                r.dropped = 1'b1;   // full: code lost, beep request
            end
        end else if (mirror_fill > 0) begin
            r.code       = key_mirror[mirror_rd];
            r.code_valid = 1'b1;
            mirror_rd    = (mirror_rd == DEPTH - 1) ? 0 : mirror_rd + 1;
            mirror_fill  = mirror_fill - 1;
            // column chosen from the flags held at pop time
            if (mod_flags[FLAG_SHIFT])     r.column = COL_SHIFT;
            else if (mod_flags[FLAG_CTRL]) r.column = mod_flags[FLAG_ALT] ? COL_CTRL_ALT
                                                                          : COL_CTRL;
            else if (mod_flags[FLAG_ALT])  r.column = COL_ALT;
            else                           r.column = COL_NORMAL;
        end
        r.locks = mod_flags[LOCK_W-1:0];
        r.held  = 6'(mirror_fill);
        expected_reports.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- driver
    // Holds the current beat until accepted, predicts on acceptance, then
    // either loads the next pending beat or idles for a random gap.
    always @(posedge aclk) begin : drive_proc
        key_beat_t  beat;
        logic       next_valid;
        logic [0:0] next_op;
        logic [7:0] next_sc;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            next_valid = s_tvalid;
            next_op    = s_tuser;
            next_sc    = s_tdata;
            if (s_tvalid && s_tready) begin
                track_keyboard_step(op_t'(s_tuser[0]), s_tdata);
                next_valid = 1'b0;
                send_gap   = no_idle ? 0 : idle_gap();
                if ($urandom_range(0, 199) == 0) no_idle <= ~no_idle;
            end
            if (!next_valid) begin
                next_sc = 8'($urandom);   // junk data while idle
                if (send_gap > 0) begin
                    send_gap--;
                end else if (key_stream.size() > 0 &&
                             !(key_stream[0].hold_until_empty &&
                               expected_reports.size() != 0)) begin
                    beat       = key_stream.pop_front();
                    next_valid = 1'b1;
                    next_op    = beat.op;
                    next_sc    = beat.sc;
                end
            end
            s_tvalid <= next_valid;
            s_tuser  <= next_op;
            s_tdata  <= next_sc;
        end
    end

    // --------------------------------------------------------------- monitor
    always @(posedge aclk) begin : watch_proc
        key_report_t want;
        logic        rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("result beat with none expected", m_tdata, 0);
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tdata[7:0] !== want.code)
                        report_mismatch("code", m_tdata[7:0], want.code);
                    if (m_tuser[0] !== want.code_valid)
                        report_mismatch("code_valid", m_tuser[0], want.code_valid);
                    if (m_tdata[10:8] !== want.column)
                        report_mismatch("map_column", m_tdata[10:8], want.column);
                    if (m_tdata[11] !== want.dropped)
                        report_mismatch("dropped_full", m_tdata[11], want.dropped);
                    if (m_tdata[12] !== want.was_modifier)
                        report_mismatch("was_modifier", m_tdata[12], want.was_modifier);
                    if (m_tdata[15:13] !== want.locks)
                        report_mismatch("lock_flags", m_tdata[15:13], want.locks);
                    if (m_tdata[21:16] !== want.held)
                        report_mismatch("held_count", m_tdata[21:16], want.held);
                end
            end
            // random back-pressure, none during no-idle stretches
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_gap();
            end
            m_tready <= rdy;
        end
    end

    // -------------------------------------------------------------- watchdog
    always @(posedge aclk) begin : watchdog_proc
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // -------------------------------------------------------------- stimulus
    initial begin : stim_proc
        int         first;
        int         n;
        int         phase;
        logic [2:0] held;
        int         target;

        // Directed: empty pops, byte extremes, swallowed codes, every column but
        // normal on a pop, lock toggles, and a pop of an emptied buffer.
        add_beat(OP_READ, 8'hFF);             // pop on empty
        add_beat(OP_KEY,  8'h00);
        add_beat(OP_KEY,  8'hFF);
        add_beat(OP_KEY,  SC_CAPS_MAKE);      // swallowed, no change
        add_beat(OP_KEY,  SC_NUM_MAKE);
        add_beat(OP_KEY,  SC_RSHIFT_MAKE);
        add_beat(OP_READ, 8'h00);             // shift column
        add_beat(OP_KEY,  SC_RSHIFT_BRK);
        add_beat(OP_KEY,  SC_LSHIFT_MAKE);
        add_beat(OP_KEY,  SC_LSHIFT_BRK);
        add_beat(OP_KEY,  SC_CTRL_MAKE);
        add_beat(OP_KEY,  SC_ALT_MAKE);
        add_beat(OP_KEY,  8'h80);             // release-style byte is queued
        add_beat(OP_READ, 8'h55);             // ctrl+alt column
        add_beat(OP_KEY,  SC_ALT_BRK);
        add_beat(OP_READ, 8'hAA);             // ctrl column
        add_beat(OP_KEY,  SC_CTRL_BRK);
        add_beat(OP_KEY,  SC_ALT_MAKE);
        add_beat(OP_KEY,  8'h7F);
        add_beat(OP_READ, 8'h01);             // alt column
        add_beat(OP_KEY,  SC_ALT_BRK);
        add_beat(OP_READ, 8'h80);             // still empty: no code, normal column
        add_beat(OP_KEY,  SC_CAPS_TOGGLE);
        add_beat(OP_KEY,  SC_NUM_TOGGLE);
        add_beat(OP_KEY,  SC_SCRL_TOGGLE);
        add_beat(OP_READ, 8'h00);             // empty again

        // Random phases of well-formed typing, fill/overflow/drain runs and noise
        target = key_stream.size() + RANDOM_ITEMS;
        phase  = 0;
        while (key_stream.size() < target) begin
            first = key_stream.size();
            case ($urandom_range(0, 3))
                0: begin
                    // fill past full, then drain to empty with one to three extra pops
                    n = $urandom_range(34, 42);
                    repeat (n) add_beat(OP_KEY, pick_scancode(10));
                    repeat (DEPTH + $urandom_range(1, 3)) add_beat(OP_READ, 8'($urandom));
                end
                1: begin
                    repeat (40) add_beat(op_t'($urandom_range(0, 1)), pick_scancode(30));
                end
                2: begin
                    // chords: press modifiers, type, pop, release
                    repeat (6) begin
                        held = 3'($urandom_range(0, 7));
                        if (held[0]) add_beat(OP_KEY, $urandom_range(0, 1) ? SC_LSHIFT_MAKE
                                                                            : SC_RSHIFT_MAKE);
                        if (held[1]) add_beat(OP_KEY, SC_CTRL_MAKE);
                        if (held[2]) add_beat(OP_KEY, SC_ALT_MAKE);
                        add_beat(OP_KEY, pick_scancode(0));
                        add_beat(OP_READ, 8'($urandom));
                        if (held[0]) add_beat(OP_KEY, $urandom_range(0, 1) ? SC_LSHIFT_BRK
                                                                            : SC_RSHIFT_BRK);
                        if (held[1]) add_beat(OP_KEY, SC_CTRL_BRK);
                        if (held[2]) add_beat(OP_KEY, SC_ALT_BRK);
                        if ($urandom_range(0, 3) == 0) add_beat(OP_KEY, pick_scancode(100));
                    end
                end
                default: begin
                    // pop-heavy noise, lots of empty pops
                    repeat (30) add_beat($urandom_range(0, 9) < 7 ? OP_READ : OP_KEY,
                                         pick_scancode(20));
                end
            endcase
            if (phase % 6 == 0) key_stream[first].hold_until_empty = 1'b1;
            phase++;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (key_stream.size() > 0 || s_tvalid || expected_reports.size() > 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
